// File: hw/rtl/crm_pkg.sv
// crm_pkg: shared types and codes for the residue merge block.
// No dependencies; imported by crt_residue_merge.
package crm_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A2,
        ST_GCD,
        ST_M,
        ST_CHK,
        ST_OVF,
        ST_D,
        ST_U,
        ST_U2,
        ST_EE_DIV,
        ST_EE_MUL,
        ST_T,
        ST_V,
        ST_OUT
    } crm_state_t;

    typedef logic [1:0] crm_status_t;

    localparam crm_status_t STATUS_OK          = 2'd0;
    localparam crm_status_t STATUS_NOT_COPRIME = 2'd1;
    localparam crm_status_t STATUS_INCONSISTENT = 2'd2;
    localparam crm_status_t STATUS_OVERFLOW    = 2'd3;

    // Register index taken from paddr[2]
    localparam logic REG_ALLOW_SHARED = 1'b0;

endpackage

// File: hw/rtl/crm_div.sv
// crm_div: restoring divider, one quotient bit per cycle.
// Standalone; used by crt_residue_merge for every quotient and remainder.
module crm_div #(
    parameter int W = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder,
    output logic         done
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    trial;
    logic          fits;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = (shifted >= {1'b0, dsr_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (go)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // subtract the divisor where it fits, shift in the quotient bit
            rem_next = fits ? trial[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// File: hw/rtl/crt_residue_merge.sv
// crt_residue_merge: incremental Chinese remainder merge, top level.
// Depends on crm_pkg (codes, state type) and crm_div (serial divider).
//
// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall  start_req, residue, modulus
// out       out  out_valid / out_stall value, combined_modulus, status
// cfg       in   APB (psel/penable)   allow_shared_factor at address 0
//
// One transaction at a time. The serial divider, W = max(ACC_BITS, RES_BITS)
// bits wide, produces one quotient bit per cycle; a division also has start and
// done hand-offs. Plain and modular products are serial; modular ones run in
// double and add phases. A merge costs six divisions plus one per gcd step and
// one per extended Euclid step E, plus E + 1 modular products and two plain
// ones.
// Reset leaves the running congruence at value 0, modulus 1, coprime mode.
// in_stall is high from acceptance until the result enters the output register;
// a result held by out_stall does not block the next transaction's work.
module crt_residue_merge
    import crm_pkg::*;
#(
    parameter int RES_BITS = 20,
    parameter int ACC_BITS = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                start_req,
    input  logic [RES_BITS-1:0] residue,
    input  logic [RES_BITS-1:0] modulus,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ACC_BITS-1:0] value,
    output logic [ACC_BITS-1:0] combined_modulus,
    output logic [1:0]          status
);

    localparam int WW  = (ACC_BITS > RES_BITS) ? ACC_BITS : RES_BITS;
    localparam int PW  = WW + RES_BITS;
    localparam int BCW = $clog2(RES_BITS + 1);
    localparam int R   = RES_BITS;

    crm_state_t state_reg, state_next;

    // configuration
    logic cfg_allow_reg;

    // running congruence
    logic [ACC_BITS-1:0] run_val_reg, run_val_next;
    logic [ACC_BITS-1:0] run_mod_reg, run_mod_next;

    // working operands
    logic [WW-1:0] n1_reg, n1_next;
    logic [WW-1:0] a1_reg, a1_next;
    logic [WW-1:0] n2_reg, n2_next;
    logic [WW-1:0] a2_reg, a2_next;
    logic [WW-1:0] gb_reg, gb_next;
    logic [WW-1:0] g_reg, g_next;
    logic [WW-1:0] q_reg, q_next;
    logic [ACC_BITS-1:0] z_reg, z_next;
    logic [R-1:0]  m_reg, m_next;
    logic [R-1:0]  d_reg, d_next;
    logic [R-1:0]  r1_reg, r1_next;
    logic [R-1:0]  nr_reg, nr_next;
    logic [R-1:0]  t0_reg, t0_next;
    logic [R-1:0]  t1_reg, t1_next;
    crm_status_t   st_reg, st_next;

    // serial multipliers
    logic [PW-1:0]  prod_reg, prod_next;
    logic [R-1:0]   mul_y_reg, mul_y_next;
    logic [R-1:0]   mm_acc_reg, mm_acc_next;
    logic [R-1:0]   mm_x_reg, mm_x_next;
    logic           mm_ph_reg, mm_ph_next;
    logic [BCW-1:0] cnt_reg, cnt_next;

    // divider port
    logic          div_go_reg, div_go_next;
    logic [WW-1:0] div_a_reg, div_a_next;
    logic [WW-1:0] div_b_reg, div_b_next;
    logic [WW-1:0] div_q, div_r;
    logic          div_done;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [ACC_BITS-1:0] out_val_reg, out_val_next;
    logic [ACC_BITS-1:0] out_mod_reg, out_mod_next;
    crm_status_t         out_st_reg, out_st_next;

    // helpers
    logic [WW-1:0] diff;
    logic [R:0]    mm_sum;
    logic [R:0]    mm_red;
    logic [R:0]    ee_nt;
    logic [PW-1:0] prod_step;
    logic [WW-1:0] vsum;
    logic          cfg_wr;

    crm_div #(.W(WW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go_reg),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    // APB: always ready, one register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ALLOW_SHARED);
    assign prdata = (paddr[2] == REG_ALLOW_SHARED) ? {31'd0, cfg_allow_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_allow_reg <= 1'b0;
        else if (cfg_wr)
            cfg_allow_reg <= pwdata[0];
    end

    assign diff = (a1_reg > a2_reg) ? (a1_reg - a2_reg) : (a2_reg - a1_reg);

    // modular step: double in phase 0, add x in phase 1, reduce once
    assign mm_sum = mm_ph_reg ? ({1'b0, mm_acc_reg} + (mul_y_reg[R-1] ? {1'b0, mm_x_reg} : '0))
                              : {mm_acc_reg, 1'b0};
    assign mm_red = (mm_sum >= {1'b0, m_reg}) ? (mm_sum - {1'b0, m_reg}) : mm_sum;

    // t0 - p modulo m, p taken from the modular accumulator
    assign ee_nt = (t0_reg >= mm_acc_reg) ? ({1'b0, t0_reg} - {1'b0, mm_acc_reg})
                                          : ({1'b0, t0_reg} + {1'b0, m_reg} - {1'b0, mm_acc_reg});

    assign prod_step = {prod_reg[PW-2:0], 1'b0} + (mul_y_reg[R-1] ? PW'(n1_reg) : '0);
    assign vsum      = prod_reg[WW-1:0] + a1_reg;

    always_comb
    begin
        state_next    = state_reg;
        run_val_next  = run_val_reg;
        run_mod_next  = run_mod_reg;
        n1_next       = n1_reg;
        a1_next       = a1_reg;
        n2_next       = n2_reg;
        a2_next       = a2_reg;
        gb_next       = gb_reg;
        g_next        = g_reg;
        q_next        = q_reg;
        z_next        = z_reg;
        m_next        = m_reg;
        d_next        = d_reg;
        r1_next       = r1_reg;
        nr_next       = nr_reg;
        t0_next       = t0_reg;
        t1_next       = t1_reg;
        st_next       = st_reg;
        prod_next     = prod_reg;
        mul_y_next    = mul_y_reg;
        mm_acc_next   = mm_acc_reg;
        mm_x_next     = mm_x_reg;
        mm_ph_next    = mm_ph_reg;
        cnt_next      = cnt_reg;
        div_go_next   = 1'b0;
        div_a_next    = div_a_reg;
        div_b_next    = div_b_reg;
        out_valid_next = (out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg;
        out_val_next  = out_val_reg;
        out_mod_next  = out_mod_reg;
        out_st_next   = out_st_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n2_next = (modulus == '0) ? WW'(1) : WW'(modulus);
                    a1_next = start_req ? '0 : WW'(run_val_reg);
                    n1_next = (start_req || run_mod_reg == '0) ? WW'(1) : WW'(run_mod_reg);
                    st_next = STATUS_OK;
                    // reduce the residue modulo the new modulus
                    div_go_next = 1'b1;
                    div_a_next  = WW'(residue);
                    div_b_next  = (modulus == '0) ? WW'(1) : WW'(modulus);
                    state_next  = ST_A2;
                end
            end
            ST_A2:
            begin
                if (div_done)
                begin
                    a2_next     = div_r;
                    gb_next     = n2_reg;
                    div_go_next = 1'b1;
                    div_a_next  = n1_reg;
                    div_b_next  = n2_reg;
                    state_next  = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (div_done)
                begin
                    gb_next = div_r;
                    div_go_next = 1'b1;
                    if (div_r == '0)
                    begin
                        g_next     = gb_reg;
                        div_a_next = n2_reg;
                        div_b_next = gb_reg;
                        state_next = ST_M;
                    end
                    else
                    begin
                        div_a_next = gb_reg;
                        div_b_next = div_r;
                    end
                end
            end
            ST_M:
            begin
                if (div_done)
                begin
                    m_next = div_q[R-1:0];
                    if (!cfg_allow_reg && g_reg != WW'(1))
                    begin
                        st_next    = STATUS_NOT_COPRIME;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        div_go_next = 1'b1;
                        div_a_next  = diff;
                        div_b_next  = g_reg;
                        state_next  = ST_CHK;
                    end
                end
            end
            ST_CHK:
            begin
                if (div_done)
                begin
                    if (div_r != '0)
                    begin
                        st_next    = STATUS_INCONSISTENT;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        q_next     = div_q;
                        prod_next  = '0;
                        mul_y_next = m_reg;
                        cnt_next   = BCW'(R);
                        state_next = ST_OVF;
                    end
                end
            end
            ST_OVF:
            begin
                if (cnt_reg != '0)
                begin
                    prod_next  = prod_step;
                    mul_y_next = {mul_y_reg[R-2:0], 1'b0};
                    cnt_next   = cnt_reg - BCW'(1);
                end
                else if (prod_reg[PW-1:ACC_BITS] != '0)
                begin
                    st_next    = STATUS_OVERFLOW;
                    state_next = ST_OUT;
                end
                else
                begin
                    z_next      = prod_reg[ACC_BITS-1:0];
                    div_go_next = 1'b1;
                    div_a_next  = q_reg;
                    div_b_next  = WW'(m_reg);
                    state_next  = ST_D;
                end
            end
            ST_D:
            begin
                if (div_done)
                begin
                    // negate the difference modulo m when a2 lies below a1
                    if (a2_reg >= a1_reg || div_r == '0)
                        d_next = div_r[R-1:0];
                    else
                        d_next = m_reg - div_r[R-1:0];
                    div_go_next = 1'b1;
                    div_a_next  = n1_reg;
                    div_b_next  = g_reg;
                    state_next  = ST_U;
                end
            end
            ST_U:
            begin
                if (div_done)
                begin
                    div_go_next = 1'b1;
                    div_a_next  = div_q;
                    div_b_next  = WW'(m_reg);
                    state_next  = ST_U2;
                end
            end
            ST_U2:
            begin
                if (div_done)
                begin
                    r1_next = div_r[R-1:0];
                    t0_next = '0;
                    t1_next = (m_reg == R'(1)) ? '0 : R'(1);
                    if (div_r == '0)
                    begin
                        // no inverse step: the inverse is zero
                        mm_acc_next = '0;
                        mm_x_next   = d_reg;
                        mul_y_next  = '0;
                        mm_ph_next  = 1'b0;
                        cnt_next    = BCW'(R);
                        state_next  = ST_T;
                    end
                    else
                    begin
                        div_go_next = 1'b1;
                        div_a_next  = WW'(m_reg);
                        div_b_next  = div_r;
                        state_next  = ST_EE_DIV;
                    end
                end
            end
            ST_EE_DIV:
            begin
                if (div_done)
                begin
                    nr_next     = div_r[R-1:0];
                    mm_x_next   = (div_q == WW'(m_reg)) ? '0 : div_q[R-1:0];
                    mm_acc_next = '0;
                    mul_y_next  = t1_reg;
                    mm_ph_next  = 1'b0;
                    cnt_next    = BCW'(R);
                    state_next  = ST_EE_MUL;
                end
            end
            ST_EE_MUL:
            begin
                if (cnt_reg != '0)
                begin
                    mm_acc_next = mm_red[R-1:0];
                    mm_ph_next  = !mm_ph_reg;
                    if (mm_ph_reg)
                    begin
                        mul_y_next = {mul_y_reg[R-2:0], 1'b0};
                        cnt_next   = cnt_reg - BCW'(1);
                    end
                end
                else
                begin
                    // advance the remainder and coefficient sequences
                    r1_next = nr_reg;
                    t0_next = t1_reg;
                    t1_next = ee_nt[R-1:0];
                    if (nr_reg == '0)
                    begin
                        mm_acc_next = '0;
                        mm_x_next   = d_reg;
                        mul_y_next  = t1_reg;
                        mm_ph_next  = 1'b0;
                        cnt_next    = BCW'(R);
                        state_next  = ST_T;
                    end
                    else
                    begin
                        div_go_next = 1'b1;
                        div_a_next  = WW'(r1_reg);
                        div_b_next  = WW'(nr_reg);
                        state_next  = ST_EE_DIV;
                    end
                end
            end
            ST_T:
            begin
                if (cnt_reg != '0)
                begin
                    mm_acc_next = mm_red[R-1:0];
                    mm_ph_next  = !mm_ph_reg;
                    if (mm_ph_reg)
                    begin
                        mul_y_next = {mul_y_reg[R-2:0], 1'b0};
                        cnt_next   = cnt_reg - BCW'(1);
                    end
                end
                else
                begin
                    prod_next  = '0;
                    mul_y_next = mm_acc_reg;
                    cnt_next   = BCW'(R);
                    state_next = ST_V;
                end
            end
            ST_V:
            begin
                if (cnt_reg != '0)
                begin
                    prod_next  = prod_step;
                    mul_y_next = {mul_y_reg[R-2:0], 1'b0};
                    cnt_next   = cnt_reg - BCW'(1);
                end
                else
                begin
                    run_val_next = vsum[ACC_BITS-1:0];
                    run_mod_next = z_reg;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = run_val_reg;
                    out_mod_next   = run_mod_reg;
                    out_st_next    = st_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_val_reg   <= '0;
            run_mod_reg   <= ACC_BITS'(1);
            cnt_reg       <= '0;
            mm_ph_reg     <= 1'b0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_val_reg   <= run_val_next;
            run_mod_reg   <= run_mod_next;
            cnt_reg       <= cnt_next;
            mm_ph_reg     <= mm_ph_next;
            div_go_reg    <= div_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n1_reg     <= n1_next;
        a1_reg     <= a1_next;
        n2_reg     <= n2_next;
        a2_reg     <= a2_next;
        gb_reg     <= gb_next;
        g_reg      <= g_next;
        q_reg      <= q_next;
        z_reg      <= z_next;
        m_reg      <= m_next;
        d_reg      <= d_next;
        r1_reg     <= r1_next;
        nr_reg     <= nr_next;
        t0_reg     <= t0_next;
        t1_reg     <= t1_next;
        st_reg     <= st_next;
        prod_reg   <= prod_next;
        mul_y_reg  <= mul_y_next;
        mm_acc_reg <= mm_acc_next;
        mm_x_reg   <= mm_x_next;
        div_a_reg  <= div_a_next;
        div_b_reg  <= div_b_next;
        out_val_reg <= out_val_next;
        out_mod_reg <= out_mod_next;
        out_st_reg  <= out_st_next;
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign value            = out_val_reg;
    assign combined_modulus = out_mod_reg;
    assign status           = out_st_reg;

endmodule
